// ----- sv/kct_pkg.sv -----
// Package for the keyed columnar transposition block.
// Holds the request and response structures and the shared codes.
// No dependencies.
package kct_pkg;

   // Fixed field widths.
   localparam int OUT_LEN_W = 11;
   localparam int KEY_W     = 64;
   localparam int CSR_IDX_W = 3;

   // Request actions.
   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_FINISH = 2'd1;
   localparam logic [1:0] ACT_PULL   = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   // Response status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD_LEN = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   // Message phases.
   localparam logic [1:0] PH_LOAD = 2'd0;
   localparam logic [1:0] PH_EMIT = 2'd1;
   localparam logic [1:0] PH_IDLE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_KEY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_BYTE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH     = 3'd5;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [7:0]           out_byte;
      logic                 out_last;
      logic [OUT_LEN_W-1:0] out_length;
   } rsp_type;

endpackage

// ----- sv/keyed_columnar_transposition.sv -----
// Top level of the keyed columnar transposition block.
// Depends on kct_pkg and kct_divider.
//
// Usage: requests enter on req_data when start is high and busy is low.
// A push stores one message byte, a finish fixes the grid and the column
// order, a pull returns the next output byte. Every request gives exactly
// one response on rsp_data, marked by rsp_strobe for a single cycle; the
// receiver must take it then, as it cannot stall the block.
// Push and no-operation requests answer in the next cycle and leave busy low,
// so one may be issued every cycle. A pull forms the address with the shared
// multiplier, reads the message memory into a register, then selects the byte
// or the pad. A finish runs the bit-serial divider, which produces one row-count
// bit per cycle, then ranks the key one column per cycle. busy stays high until
// the response cycle.
// Configuration goes through the csr_ port, which is always ready, and
// should only be written while the block is idle.
// Reset (synchronous) clears the counters and returns to the loading phase;
// the message memory is not cleared and needs no clearing pass.
module keyed_columnar_transposition #(
   parameter int MAX_BYTES   = 1024,
   parameter int MAX_COLUMNS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  kct_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output kct_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kct_pkg::KEY_W-1:0]         csr_data
);

   import kct_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BYTES + 1);
   localparam int LEN_W  = $clog2(MAX_BYTES + MAX_COLUMNS);
   localparam int ADDR_W = $clog2(MAX_BYTES);
   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int LCOL_W = $clog2(MAX_COLUMNS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_RANK = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // Configuration registers.
   logic            cfg_decode_ff;
   logic            cfg_use_key_ff;
   logic [4:0]      cfg_cols_ff;
   logic [7:0]      cfg_pad_ff;
   logic [KEY_W-1:0] cfg_key_lo_ff;
   logic [KEY_W-1:0] cfg_key_hi_ff;

   // Sequencer and message state.
   logic [2:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  rows_ff, rows_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  minor_ff, minor_in;
   logic [LEN_W-1:0]  major_ff, major_in;
   logic [LCOL_W-1:0] lat_cols_ff, lat_cols_in;
   logic              lat_decode_ff, lat_decode_in;
   logic [7:0]        lat_pad_ff, lat_pad_in;
   logic [COL_W-1:0]  rank_idx_ff, rank_idx_in;
   logic [LEN_W-1:0]  prod_ff, prod_in;
   logic [LEN_W-1:0]  addc_ff, addc_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   // Column rank tables and the message memory.
   logic [COL_W-1:0] rank_ff [MAX_COLUMNS];
   logic [COL_W-1:0] inv_ff  [MAX_COLUMNS];
   logic [7:0]       mem     [MAX_BYTES];
   logic [7:0]       rdata_ff;
   logic             hit_ff;

   logic                req_accept;
   logic                div_start;
   logic                div_done;
   logic [CNT_W-1:0]    div_q;
   logic [LCOL_W-1:0]   div_r;
   logic [LCOL_W-1:0]   clamped_cols;
   logic [CNT_W-1:0]    push_cnt;
   logic                push_room;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic                rank_we;
   logic [2*KEY_W-1:0]  key_all;
   logic [7:0]          key_cur;
   logic [MAX_COLUMNS-1:0] rank_hits;
   logic [COL_W-1:0]    rank_val;
   logic [LEN_W-1:0]    mul_a, mul_b, add_c;
   logic [2*LEN_W-1:0]  mul_full;
   logic [LEN_W-1:0]    rd_idx;
   logic                rem_nz;
   logic [LEN_W-1:0]    rows_calc, len_calc;
   logic [LEN_W+OUT_LEN_W-1:0] len_wide;
   logic [LEN_W-1:0]    pos_next;
   logic [LEN_W-1:0]    wrap_lim;

   assign req_accept = start && !busy;
   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_decode_ff  <= 1'b0;
         cfg_use_key_ff <= 1'b0;
         cfg_cols_ff    <= 5'd1;
         cfg_pad_ff     <= '0;
         cfg_key_lo_ff  <= '0;
         cfg_key_hi_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECODE_MODE:  cfg_decode_ff  <= csr_data[0];
            CSR_USE_KEY:      cfg_use_key_ff <= csr_data[0];
            CSR_COLUMN_COUNT: cfg_cols_ff    <= csr_data[4:0];
            CSR_PAD_BYTE:     cfg_pad_ff     <= csr_data[7:0];
            CSR_KEY_LOW:      cfg_key_lo_ff  <= csr_data;
            CSR_KEY_HIGH:     cfg_key_hi_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Column count limited to the supported range.
   assign clamped_cols = (cfg_cols_ff == '0) ? LCOL_W'(1) :
                         (cfg_cols_ff > 5'(MAX_COLUMNS)) ? LCOL_W'(MAX_COLUMNS) :
                         LCOL_W'(cfg_cols_ff);

   // Row count and remainder come from the serial divider.
   assign div_start = req_accept && (req_data.action == ACT_FINISH);

   kct_divider #(
      .N (CNT_W),
      .D (LCOL_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (count_ff),
      .divisor   (clamped_cols),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign rem_nz    = (div_r != '0);
   assign rows_calc = LEN_W'(div_q) + LEN_W'(rem_nz);
   assign len_calc  = LEN_W'(count_ff) + (rem_nz ? LEN_W'(lat_cols_ff - div_r) : '0);
   assign len_wide  = (LEN_W + OUT_LEN_W)'(len_calc);

   // Rank of one key column per cycle: count the smaller keys, ties to the left.
   assign key_all = {cfg_key_hi_ff, cfg_key_lo_ff};
   assign key_cur = key_all[8*rank_idx_ff +: 8];

   always_comb begin
      rank_hits = '0;
      for (int j = 0; j < MAX_COLUMNS; j++) begin
         if ((LCOL_W'(j) < lat_cols_ff) &&
             ((key_all[8*j +: 8] < key_cur) ||
              ((key_all[8*j +: 8] == key_cur) && (COL_W'(j) < rank_idx_ff)))) begin
            rank_hits[j] = 1'b1;
         end
      end
   end

   assign rank_val = cfg_use_key_ff ? COL_W'($countones(rank_hits)) : rank_idx_ff;

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_ff[rank_idx_ff] <= rank_val;
         inv_ff[rank_val]     <= rank_idx_ff;
      end
   end

   // Source address of the next output byte: row * columns + column when
   // encoding, rank * rows + row when decoding.
   assign mul_a    = lat_decode_ff ? LEN_W'(rank_ff[minor_ff[COL_W-1:0]]) : minor_ff;
   assign mul_b    = lat_decode_ff ? rows_ff : LEN_W'(lat_cols_ff);
   assign add_c    = lat_decode_ff ? major_ff : LEN_W'(inv_ff[major_ff[COL_W-1:0]]);
   assign mul_full = (2*LEN_W)'(mul_a) * (2*LEN_W)'(mul_b);
   assign rd_idx   = prod_ff + addc_ff;

   // Push addressing: a push after finish starts a new message.
   assign push_cnt  = (phase_ff != PH_LOAD) ? '0 : count_ff;
   assign push_room = (push_cnt < CNT_W'(MAX_BYTES));
   assign mem_waddr = push_cnt[ADDR_W-1:0];

   // Message memory: one write port for pushes, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         rdata_ff <= mem[rd_idx[ADDR_W-1:0]];
         hit_ff   <= (rd_idx < LEN_W'(count_ff));
      end
   end

   // Output walk counters.
   assign pos_next = pos_ff + 1'b1;
   assign wrap_lim = lat_decode_ff ? LEN_W'(lat_cols_ff) : rows_ff;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      rows_in       = rows_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      minor_in      = minor_ff;
      major_in      = major_ff;
      lat_cols_in   = lat_cols_ff;
      lat_decode_in = lat_decode_ff;
      lat_pad_in    = lat_pad_ff;
      rank_idx_in   = rank_idx_ff;
      prod_in       = prod_ff;
      addc_in       = addc_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      rank_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_in = '0;
               unique case (req_data.action)
                  ACT_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (phase_ff != PH_LOAD) begin
                        pos_in   = '0;
                        phase_in = PH_LOAD;
                     end
                     if (push_room) begin
                        mem_we   = 1'b1;
                        count_in = push_cnt + 1'b1;
                     end else begin
                        count_in      = push_cnt;
                        rsp_in.status = ST_FULL;
                     end
                  end
                  ACT_FINISH: begin
                     lat_cols_in   = clamped_cols;
                     lat_decode_in = cfg_decode_ff;
                     lat_pad_in    = cfg_pad_ff;
                     rank_idx_in   = '0;
                     state_in      = S_DIV;
                  end
                  ACT_PULL: begin
                     if ((phase_ff != PH_EMIT) || (pos_ff >= len_ff) || (rows_ff == '0)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_NONE;
                     end else begin
                        prod_in  = mul_full[LEN_W-1:0];
                        addc_in  = add_c;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_RANK;
            end
         end
         S_RANK: begin
            rank_we     = 1'b1;
            rank_idx_in = rank_idx_ff + 1'b1;
            if (LCOL_W'(rank_idx_ff) == (lat_cols_ff - 1'b1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            pos_in        = '0;
            minor_in      = '0;
            major_in      = '0;
            state_in      = S_IDLE;
            if (lat_decode_ff && rem_nz) begin
               rsp_in.status = ST_BAD_LEN;
               rows_in       = '0;
               len_in        = '0;
               phase_in      = PH_IDLE;
            end else begin
               rows_in           = rows_calc;
               len_in            = len_calc;
               phase_in          = PH_EMIT;
               rsp_in.out_length = len_wide[OUT_LEN_W-1:0];
            end
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_strobe_in   = 1'b1;
            rsp_in          = '0;
            rsp_in.out_byte = hit_ff ? rdata_ff : lat_pad_ff;
            pos_in          = pos_next;
            state_in        = S_IDLE;
            if (pos_next >= len_ff) begin
               rsp_in.out_last = 1'b1;
               phase_in        = PH_IDLE;
            end
            if (minor_ff == (wrap_lim - 1'b1)) begin
               minor_in = '0;
               major_in = major_ff + 1'b1;
            end else begin
               minor_in = minor_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_LOAD;
         count_ff      <= '0;
         rows_ff       <= '0;
         len_ff        <= '0;
         pos_ff        <= '0;
         minor_ff      <= '0;
         major_ff      <= '0;
         lat_cols_ff   <= LCOL_W'(1);
         lat_decode_ff <= 1'b0;
         lat_pad_ff    <= '0;
         rank_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         rows_ff       <= rows_in;
         len_ff        <= len_in;
         pos_ff        <= pos_in;
         minor_ff      <= minor_in;
         major_ff      <= major_in;
         lat_cols_ff   <= lat_cols_in;
         lat_decode_ff <= lat_decode_in;
         lat_pad_ff    <= lat_pad_in;
         rank_idx_ff   <= rank_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      addc_ff <= addc_in;
      rsp_ff  <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   // A response is only ever issued as the sequencer returns to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response issued while the sequencer is busy");

   // A push request is answered in the very next cycle.
   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.action == ACT_PUSH)) |=> rsp_strobe)
      else $error("push request not answered in the next cycle");

   // The read position never runs past the result length.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff)
      else $error("read position beyond result length");

   // The final byte of a result closes the output phase.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.out_last) |-> (phase_ff == PH_IDLE))
      else $error("final byte delivered but output phase still open");
`endif

endmodule

// ----- sv/kct_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Used by the transposition block to size the grid. No package dependencies.
module kct_divider #(
   parameter int N = 11,
   parameter int D = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic [D-1:0] remainder
);

   localparam int STEP_W = $clog2(N + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [N-1:0]      work_ff;
   logic [D-1:0]      rem_ff;
   logic [D-1:0]      dvs_ff;
   logic [D:0]        trial;
   logic [D:0]        diff;
   logic              fits;

   // Trial subtraction for the next quotient bit.
   assign trial = {rem_ff, work_ff[N-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(N - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend shifts out at the top while quotient bits shift in below.
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[D-1:0] : trial[D-1:0];
         work_ff <= {work_ff[N-2:0], fits};
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule
